// File: hdl/hsrd_pkg.sv
// Shared types, constants and the coil lookup for the half-step ramp driver.
package hsrd_pkg;

  localparam int TABLE_DEPTH   = 8;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int COIL_W        = 4;
  localparam int SPEED_W       = 8;
  localparam int TIME_W        = 16;
  localparam int TICK_W        = 8;
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int DIV_STEPS     = TIME_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
  localparam int ON_TIME_SCALE = 100;
  localparam int SCALE_W       = 7;
  localparam int PROD_W        = TIME_W + SCALE_W;

  localparam logic [TICK_W-1:0]  ACCEL_PERIOD_RST  = 8'd10;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST     = 8'd200;
  localparam logic [SPEED_W-1:0] INIT_SPEED_RST    = 8'd1;
  localparam logic [TIME_W-1:0]  RAMP_NUM_RST      = 16'd60000;
  localparam logic [TIME_W-1:0]  INIT_ON_TIME_RST  = 16'd1000;
  localparam logic [SPEED_W-1:0] SPEED_MAX         = 8'hFF;
  localparam logic [TICK_W-1:0]  TICK_MAX          = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 2'd0,
    OP_STEP       = 2'd1,
    OP_RAMP_RESET = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_PERIOD  = 3'd0,
    CFG_MAX_SPEED     = 3'd1,
    CFG_INIT_SPEED    = 3'd2,
    CFG_RAMP_NUM      = 3'd3,
    CFG_INIT_ON_TIME  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_iter;
    logic on_time_wr;
  } cmd_t;

  typedef struct packed {
    logic needs_div;
    logic out_free;
  } status_t;

  function automatic logic [COIL_W-1:0] coil_lookup(input logic [IDX_W-1:0] idx);
    logic [COIL_W-1:0] pat;
    case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

endpackage

// File: hdl/hsrd_in_if.sv
// Input channel: command word carrying opcode and direction.
interface hsrd_in_if;
  logic                        valid;
  logic                        ready;
  logic [hsrd_pkg::OP_W-1:0]   opcode;
  logic                        direction;

  modport source (output valid, output opcode, output direction, input ready);
  modport sink   (input valid, input opcode, input direction, output ready);
endinterface

// File: hdl/hsrd_out_if.sv
// Output channel: coil pattern, on-time and speed word.
interface hsrd_out_if;
  logic                           valid;
  logic                           ready;
  logic [hsrd_pkg::COIL_W-1:0]    coil_pattern;
  logic [hsrd_pkg::TIME_W-1:0]    on_time;
  logic [hsrd_pkg::SPEED_W-1:0]   speed;

  modport source (output valid, output coil_pattern, output on_time, output speed,
                  input ready);
  modport sink   (input valid, input coil_pattern, input on_time, input speed,
                  output ready);
endinterface

// File: hdl/stepper_half_step_ramp_driver.sv
// Top level of the half-step stepper sequencer with acceleration ramp.
//
// Each input word is a tick, a step or a ramp reset, and each gives exactly one
// output word, held in an output register until taken. Ticks, ramp resets and
// steps that do not raise the speed stay in ST_IDLE, so one such word can be
// accepted every cycle while the output side keeps up. A step that raises the
// speed while it is still below max_speed also starts the on-time update
// ((ramp_numerator / new speed) * 100, kept to 16 bits): its own output word
// is ready right away (it shows the on-time before the update), but the input
// is held off while the restoring divider runs (one quotient bit per cycle) in
// ST_DIVIDE and while the quotient is scaled by 100 in ST_WRITE. Config
// registers are to be written through cfg_we_i / cfg_idx_i / cfg_data_i only
// while the block is idle; the block does not enforce this. Writes to unknown
// indexes are dropped.
module stepper_half_step_ramp_driver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hsrd_in_if.sink                           in_s,
  hsrd_out_if.source                        out_m,
  input  logic                              cfg_we_i,
  input  logic [hsrd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hsrd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  hsrd_pkg::cmd_t    cmd;
  hsrd_pkg::status_t status;

  // sequence acceptance and the divide
  hsrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_s.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // hold state, config and the output register
  hsrd_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (in_s.opcode),
    .direction_i    (in_s.direction),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_m.valid),
    .out_ready_i    (out_m.ready),
    .coil_pattern_o (out_m.coil_pattern),
    .on_time_o      (out_m.on_time),
    .speed_o        (out_m.speed)
  );

endmodule

// File: hdl/hsrd_ctrl.sv
// Controller state machine: accepts words and sequences the serial divide.
module hsrd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hsrd_pkg::status_t status_i,
  output hsrd_pkg::cmd_t    cmd_o
);

  hsrd_pkg::state_e               state_q, state_d;
  logic [hsrd_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           accept;
  logic                           last_iter;

  assign last_iter = (cnt_q == hsrd_pkg::DIV_CNT_W'(hsrd_pkg::DIV_STEPS - 1));
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      hsrd_pkg::ST_IDLE: begin
        if (accept && status_i.needs_div) state_d = hsrd_pkg::ST_DIVIDE;
      end
      hsrd_pkg::ST_DIVIDE: begin
        if (last_iter) state_d = hsrd_pkg::ST_WRITE;
      end
      hsrd_pkg::ST_WRITE: begin
        state_d = hsrd_pkg::ST_IDLE;
      end
      default: state_d = hsrd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.accept      = 1'b0;
    cmd_o.div_iter    = 1'b0;
    cmd_o.on_time_wr  = 1'b0;
    case (state_q)
      hsrd_pkg::ST_IDLE: begin
        in_ready_o   = status_i.out_free;
        cmd_o.accept = in_valid_i && status_i.out_free;
      end
      hsrd_pkg::ST_DIVIDE: begin
        cmd_o.div_iter = 1'b1;
      end
      hsrd_pkg::ST_WRITE: begin
        cmd_o.on_time_wr = 1'b1;
      end
      default: ;
    endcase
  end

  assign cnt_d = (state_q == hsrd_pkg::ST_DIVIDE) ? cnt_q + 1'b1 : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsrd_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: hdl/hsrd_datapath.sv
// Datapath: config registers, motor state, serial divider and result register.
module hsrd_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hsrd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hsrd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [hsrd_pkg::OP_W-1:0]         opcode_i,
  input  logic                              direction_i,
  input  hsrd_pkg::cmd_t                    cmd_i,
  output hsrd_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [hsrd_pkg::COIL_W-1:0]       coil_pattern_o,
  output logic [hsrd_pkg::TIME_W-1:0]       on_time_o,
  output logic [hsrd_pkg::SPEED_W-1:0]      speed_o
);

  // configuration
  logic [hsrd_pkg::TICK_W-1:0]  accel_period_q;
  logic [hsrd_pkg::SPEED_W-1:0] max_speed_q, init_speed_q;
  logic [hsrd_pkg::TIME_W-1:0]  ramp_num_q, init_on_time_q;

  // motor state
  logic [hsrd_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [hsrd_pkg::SPEED_W-1:0] speed_q, speed_d;
  logic [hsrd_pkg::TIME_W-1:0]  pending_q, pending_d;
  logic [hsrd_pkg::TICK_W-1:0]  ticks_q, ticks_d;

  // divider
  logic [hsrd_pkg::TIME_W-1:0]  quo_q, quo_d;
  logic [hsrd_pkg::SPEED_W-1:0] rem_q, rem_d;
  logic [hsrd_pkg::SPEED_W-1:0] dvsr_q, dvsr_d;
  logic [hsrd_pkg::SPEED_W:0]   rem_sh, rem_sub;
  logic                         rem_ge;
  logic [hsrd_pkg::PROD_W-1:0]  prod;

  // result register
  logic                         out_valid_q, out_valid_d;
  logic [hsrd_pkg::COIL_W-1:0]  coil_q, coil_d;
  logic [hsrd_pkg::TIME_W-1:0]  out_time_q, out_time_d;
  logic [hsrd_pkg::SPEED_W-1:0] out_speed_q, out_speed_d;

  logic [hsrd_pkg::SPEED_W-1:0] speed_inc;
  logic [hsrd_pkg::IDX_W-1:0]   idx_step;
  logic                         ramp;

  assign speed_inc = (speed_q == hsrd_pkg::SPEED_MAX) ? speed_q : speed_q + 1'b1;
  assign idx_step  = direction_i ? idx_q - 1'b1 : idx_q + 1'b1;
  assign ramp      = ticks_q > accel_period_q;

  assign status_o.needs_div = (hsrd_pkg::op_e'(opcode_i) == hsrd_pkg::OP_STEP) && ramp &&
                              (speed_q < max_speed_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // one restoring-division digit per cycle
  assign rem_sh  = {rem_q, quo_q[hsrd_pkg::TIME_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvsr_q};
  assign rem_sub = rem_sh - {1'b0, dvsr_q};
  assign prod    = quo_q * hsrd_pkg::SCALE_W'(hsrd_pkg::ON_TIME_SCALE);

  always_comb begin
    idx_d       = idx_q;
    speed_d     = speed_q;
    pending_d   = pending_q;
    ticks_d     = ticks_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvsr_d      = dvsr_q;
    coil_d      = coil_q;
    out_time_d  = out_time_q;
    out_speed_d = out_speed_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.accept) begin
      out_valid_d = 1'b1;
      coil_d      = '0;
      out_time_d  = pending_q;
      out_speed_d = speed_q;
      case (hsrd_pkg::op_e'(opcode_i))
        hsrd_pkg::OP_TICK: begin
          if (ticks_q != hsrd_pkg::TICK_MAX) ticks_d = ticks_q + 1'b1;
        end
        hsrd_pkg::OP_STEP: begin
          idx_d  = idx_step;
          coil_d = hsrd_pkg::coil_lookup(idx_step);
          if (ramp) begin
            speed_d     = speed_inc;
            out_speed_d = speed_inc;
            ticks_d     = '0;
            // load the divider; the on-time update follows only if the speed was below max_speed
            quo_d       = ramp_num_q;
            rem_d       = '0;
            dvsr_d      = speed_inc;
          end
        end
        hsrd_pkg::OP_RAMP_RESET: begin
          idx_d       = {idx_q[hsrd_pkg::IDX_W-1:1], 1'b0};
          speed_d     = init_speed_q;
          pending_d   = init_on_time_q;
          out_time_d  = init_on_time_q;
          out_speed_d = init_speed_q;
        end
        default: ;
      endcase
    end

    if (cmd_i.div_iter) begin
      rem_d = rem_ge ? rem_sub[hsrd_pkg::SPEED_W-1:0] : rem_sh[hsrd_pkg::SPEED_W-1:0];
      quo_d = {quo_q[hsrd_pkg::TIME_W-2:0], rem_ge};
    end

    if (cmd_i.on_time_wr) begin
      pending_d = prod[hsrd_pkg::TIME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_period_q <= hsrd_pkg::ACCEL_PERIOD_RST;
      max_speed_q    <= hsrd_pkg::MAX_SPEED_RST;
      init_speed_q   <= hsrd_pkg::INIT_SPEED_RST;
      ramp_num_q     <= hsrd_pkg::RAMP_NUM_RST;
      init_on_time_q <= hsrd_pkg::INIT_ON_TIME_RST;
    end else if (cfg_we_i) begin
      case (hsrd_pkg::cfg_idx_e'(cfg_idx_i))
        hsrd_pkg::CFG_ACCEL_PERIOD: accel_period_q <= cfg_data_i[hsrd_pkg::TICK_W-1:0];
        hsrd_pkg::CFG_MAX_SPEED:    max_speed_q    <= cfg_data_i[hsrd_pkg::SPEED_W-1:0];
        hsrd_pkg::CFG_INIT_SPEED:   init_speed_q   <= cfg_data_i[hsrd_pkg::SPEED_W-1:0];
        hsrd_pkg::CFG_RAMP_NUM:     ramp_num_q     <= cfg_data_i[hsrd_pkg::TIME_W-1:0];
        hsrd_pkg::CFG_INIT_ON_TIME: init_on_time_q <= cfg_data_i[hsrd_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      speed_q     <= hsrd_pkg::INIT_SPEED_RST;
      pending_q   <= hsrd_pkg::INIT_ON_TIME_RST;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      speed_q     <= speed_d;
      pending_q   <= pending_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    dvsr_q      <= dvsr_d;
    coil_q      <= coil_d;
    out_time_q  <= out_time_d;
    out_speed_q <= out_speed_d;
  end

  assign out_valid_o    = out_valid_q;
  assign coil_pattern_o = coil_q;
  assign on_time_o      = out_time_q;
  assign speed_o        = out_speed_q;

endmodule

// File: hdl/hsrd_checker.sv
// Port-level checks for the half-step ramp driver, bound to the top level.
module hsrd_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [hsrd_pkg::OP_W-1:0]       in_opcode_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [hsrd_pkg::COIL_W-1:0]     out_coil_i,
  input  logic [hsrd_pkg::TIME_W-1:0]     out_on_time_i,
  input  logic [hsrd_pkg::SPEED_W-1:0]    out_speed_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_coil_i) &&
      $stable(out_on_time_i) && $stable(out_speed_i))
    else $error("output word changed while stalled");

  // coils show only half-step patterns, or no coil at all
  a_coil_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_coil_i == 4'h0 || $countones(out_coil_i) == 1 ||
      out_coil_i == 4'h3 || out_coil_i == 4'h6 || out_coil_i == 4'hC ||
      out_coil_i == 4'h9)
    else $error("illegal coil pattern");

  // a tick drives no coils
  a_tick_coil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_opcode_i == hsrd_pkg::OP_TICK |=> out_valid_i && out_coil_i == 4'h0)
    else $error("tick word drives coils");

  // a step always energizes a coil
  a_step_coil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_opcode_i == hsrd_pkg::OP_STEP |=> out_valid_i && out_coil_i != 4'h0)
    else $error("step word without coil pattern");

endmodule

bind stepper_half_step_ramp_driver hsrd_checker u_hsrd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_s.valid),
  .in_ready_i    (in_s.ready),
  .in_opcode_i   (in_s.opcode),
  .out_valid_i   (out_m.valid),
  .out_ready_i   (out_m.ready),
  .out_coil_i    (out_m.coil_pattern),
  .out_on_time_i (out_m.on_time),
  .out_speed_i   (out_m.speed)
);
